/* src/ipv4_dotted_quad_parser_unit_macros.svh */
// Assertion helpers for the checker file of the parser unit.
// Both forms are disabled while the active-low reset is asserted.
`ifndef IPV4_DOTTED_QUAD_PARSER_UNIT_MACROS_SVH
`define IPV4_DOTTED_QUAD_PARSER_UNIT_MACROS_SVH

// A condition that must hold at every rising clock edge.
`define IPV4DQ_ASSERT(name, clk, rstn, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define IPV4DQ_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ipv4dq_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types, character codes and mask tables of the dotted-quad parser.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  // Character codes used by the parser.
  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // Largest legal octet value and the saturation point of the accumulator.
  localparam logic [8:0] OctetMax = 9'd255;
  localparam logic [8:0] AccSat   = 9'd256;

  // Index of the last octet.
  localparam logic [1:0] LastOctet = 2'd3;

  // Register index of mask_mode, as decoded from the word address bit.
  localparam logic MaskModeReg = 1'b0;

  // Result error codes.
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_RANGE  = 3'd1,
    ERR_DOT    = 3'd2,
    ERR_STRAY  = 3'd3,
    ERR_MASK   = 3'd4,
    ERR_CONTIG = 3'd5
  } err_e;

  // One character handed to the parsing core.
  typedef struct packed {
    logic       fire;
    logic [7:0] text_char;
    logic       end_of_text;
    logic       mask_mode;
  } step_t;

  // Result that the core produces on an end-of-text transaction.
  typedef struct packed {
    logic [31:0] address_value;
    err_e        error_code;
    logic [5:0]  prefix_length;
  } res_t;

  // True for the octet values that may appear in a subnet mask.
  function automatic logic mask_octet_ok(input logic [7:0] v);
    logic ok;
    case (v)
      8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Number of leading ones in a legal mask octet; zero for anything else.
  function automatic logic [3:0] mask_octet_ones(input logic [7:0] v);
    logic [3:0] n;
    case (v)
      8'h80:   n = 4'd1;
      8'hC0:   n = 4'd2;
      8'hE0:   n = 4'd3;
      8'hF0:   n = 4'd4;
      8'hF8:   n = 4'd5;
      8'hFC:   n = 4'd6;
      8'hFE:   n = 4'd7;
      8'hFF:   n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

/* src/ipv4dq_if.sv */
// ----------------------------------------------------------------------------
// ipv4dq_if
// Valid/ready channels for the character stream and the parse results.
// ----------------------------------------------------------------------------

// Character stream: one text character or an end-of-text marker.
interface ipv4dq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

// Result stream: one parsed address per text.
interface ipv4dq_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] address_value;
  logic [2:0]  error_code;
  logic [5:0]  prefix_length;

  modport source (output valid, output address_value, output error_code,
                  output prefix_length, input ready);
  modport sink   (input valid, input address_value, input error_code,
                  input prefix_length, output ready);
endinterface

/* src/ipv4dq_core.sv */
// ----------------------------------------------------------------------------
// ipv4dq_core
// Parsing state and the per-character update of the dotted-quad parser.
// ----------------------------------------------------------------------------
module ipv4dq_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipv4dq_pkg::step_t  step_i,
  output ipv4dq_pkg::res_t   res_o
);

  logic [1:0]       idx_q, idx_d;
  logic [8:0]       acc_q, acc_d;
  logic [31:0]      asm_q, asm_d;
  logic [7:0]       prior_q, prior_d;
  ipv4dq_pkg::err_e err_q, err_d;
  logic [5:0]       pfx_q, pfx_d;

  logic             is_digit;
  logic [11:0]      acc_next;
  logic [7:0]       oct;
  ipv4dq_pkg::err_e close_err;
  logic [31:0]      asm_commit;
  logic [5:0]       pfx_commit;
  ipv4dq_pkg::err_e end_err;

  // Decimal accumulate with saturation at 256.
  assign is_digit = step_i.text_char inside {[ipv4dq_pkg::CharZero:ipv4dq_pkg::CharNine]};
  assign acc_next = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
                  + {8'h00, 4'(step_i.text_char - ipv4dq_pkg::CharZero)};

  // Checks applied when an octet closes, in priority order.
  assign oct = acc_q[7:0];
  always_comb begin
    if (acc_q > ipv4dq_pkg::OctetMax) begin
      close_err = ipv4dq_pkg::ERR_RANGE;
    end else if (step_i.mask_mode && !ipv4dq_pkg::mask_octet_ok(oct)) begin
      close_err = ipv4dq_pkg::ERR_MASK;
    end else if (step_i.mask_mode && (prior_q != 8'hFF) && (oct != 8'h00)) begin
      close_err = ipv4dq_pkg::ERR_CONTIG;
    end else begin
      close_err = ipv4dq_pkg::ERR_NONE;
    end
  end

  assign asm_commit = {asm_q[23:0], oct};
  assign pfx_commit = step_i.mask_mode
                    ? pfx_q + {2'b00, ipv4dq_pkg::mask_octet_ones(oct)} : pfx_q;

  // Final error code of a text closed by the current end marker.
  always_comb begin
    if (err_q != ipv4dq_pkg::ERR_NONE) begin
      end_err = err_q;
    end else if (close_err != ipv4dq_pkg::ERR_NONE) begin
      end_err = close_err;
    end else if (idx_q != ipv4dq_pkg::LastOctet) begin
      end_err = ipv4dq_pkg::ERR_DOT;
    end else begin
      end_err = ipv4dq_pkg::ERR_NONE;
    end
  end

  // Result of the end marker; only sampled on an end-of-text transaction.
  always_comb begin
    res_o.error_code = end_err;
    if (end_err != ipv4dq_pkg::ERR_NONE) begin
      res_o.address_value = '0;
      res_o.prefix_length = '0;
    end else begin
      res_o.address_value = asm_commit;
      res_o.prefix_length = step_i.mask_mode ? pfx_commit : 6'd0;
    end
  end

  // Next state for one character transaction.
  always_comb begin
    idx_d   = idx_q;
    acc_d   = acc_q;
    asm_d   = asm_q;
    prior_d = prior_q;
    err_d   = err_q;
    pfx_d   = pfx_q;
    if (step_i.fire) begin
      if (step_i.end_of_text) begin
        idx_d   = '0;
        acc_d   = '0;
        asm_d   = '0;
        prior_d = 8'hFF;
        err_d   = ipv4dq_pkg::ERR_NONE;
        pfx_d   = '0;
      end else if (err_q == ipv4dq_pkg::ERR_NONE) begin
        if (is_digit) begin
          acc_d = (acc_next > {3'b000, ipv4dq_pkg::AccSat})
                ? ipv4dq_pkg::AccSat : acc_next[8:0];
        end else begin
          acc_d = '0;
          if (close_err != ipv4dq_pkg::ERR_NONE) begin
            err_d = close_err;
          end else begin
            asm_d = asm_commit;
            pfx_d = pfx_commit;
            if (step_i.mask_mode) begin
              prior_d = oct;
            end
            if (idx_q != ipv4dq_pkg::LastOctet && step_i.text_char == ipv4dq_pkg::CharDot) begin
              idx_d = idx_q + 2'd1;
            end else if (idx_q != ipv4dq_pkg::LastOctet) begin
              err_d = ipv4dq_pkg::ERR_DOT;
            end else begin
              err_d = ipv4dq_pkg::ERR_STRAY;
            end
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      acc_q   <= '0;
      asm_q   <= '0;
      prior_q <= 8'hFF;
      err_q   <= ipv4dq_pkg::ERR_NONE;
      pfx_q   <= '0;
    end else begin
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      asm_q   <= asm_d;
      prior_q <= prior_d;
      err_q   <= err_d;
      pfx_q   <= pfx_d;
    end
  end

endmodule

/* src/ipv4_dotted_quad_parser_unit.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_unit
// Streaming parser of dotted-decimal IPv4 addresses and subnet masks.
// ----------------------------------------------------------------------------
// Usage: characters of a text such as "10.0.0.1" arrive on in_i, one per
// transaction; a transaction with end_of_text high closes the text and its
// character is ignored. Each closed text yields one transaction on res_o
// carrying the address, an error code and, in mask mode, the prefix length.
// Characters that are not end markers yield nothing.
// The mask_mode register (APB, address 0, bit 0) selects mask parsing; it
// must be written only while no text is in flight, a rule on the user that
// the block does not enforce. A character is captured in the input register
// and then processed by the parsing core; the result of an end marker goes
// into the result register, from which it is shown on res_o.
// Throughput: one character per cycle while no end marker waits for the
// result register.
// Stall: while res_o is held back, characters still flow; only a further end
// marker waits in the input register until the pending result is taken.
// Reset clears the parsing state, the result valid flag and the mask_mode register.
module ipv4_dotted_quad_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipv4dq_char_if.sink   in_i,
  ipv4dq_res_if.source  res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             eot_q;
  logic             out_valid_q, out_valid_d;
  ipv4dq_pkg::res_t res_q;
  logic             mask_q;

  logic             out_free;
  logic             advance;
  logic             in_take;
  ipv4dq_pkg::step_t step;
  ipv4dq_pkg::res_t  res;

  // Configuration port: one register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ipv4dq_pkg::MaskModeReg) ? {31'd0, mask_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == ipv4dq_pkg::MaskModeReg)) begin
      mask_q <= pwdata[0];
    end
  end

  // Handshake: the held character moves on unless it is an end marker
  // that finds the result register occupied.
  assign out_free = !out_valid_q || res_o.ready;
  assign advance  = in_valid_q && (!eot_q || out_free);
  assign in_take  = in_i.valid && in_i.ready;
  assign in_i.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= in_i.text_char;
      eot_q  <= in_i.end_of_text;
    end
  end

  // Parsing core.
  assign step.fire        = advance;
  assign step.text_char   = char_q;
  assign step.end_of_text = eot_q;
  assign step.mask_mode   = mask_q;

  ipv4dq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  // Result register.
  always_comb begin
    if (advance && eot_q) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && eot_q) begin
      res_q <= res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.address_value = res_q.address_value;
  assign res_o.error_code    = res_q.error_code;
  assign res_o.prefix_length = res_q.prefix_length;

endmodule

/* src/ipv4dq_checker.sv */
// ----------------------------------------------------------------------------
// ipv4dq_checker
// Port-level checks of the parser unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "ipv4_dotted_quad_parser_unit_macros.svh"

module ipv4dq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] res_address_i,
  input logic [2:0]  res_error_i,
  input logic [5:0]  res_prefix_i
);

  // A result transaction that is stalled stays offered.
  `IPV4DQ_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i, "result dropped while stalled")

  // Only defined error codes reach the result channel.
  `IPV4DQ_ASSERT(a_err_code, clk_i, rst_ni, !res_valid_i || (res_error_i <= ipv4dq_pkg::ERR_CONTIG), "undefined error code")

  // A failed parse carries neither an address nor a prefix length.
  `IPV4DQ_ASSERT(a_err_zero, clk_i, rst_ni, !res_valid_i || (res_error_i == ipv4dq_pkg::ERR_NONE) || ((res_address_i == 32'd0) && (res_prefix_i == 6'd0)), "error result with data")

  // A prefix never exceeds the address width.
  `IPV4DQ_ASSERT(a_pfx_range, clk_i, rst_ni, !res_valid_i || (res_prefix_i <= 6'd32), "prefix length out of range")

endmodule

bind ipv4_dotted_quad_parser_unit ipv4dq_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_address_i (res_o.address_value),
  .res_error_i   (res_o.error_code),
  .res_prefix_i  (res_o.prefix_length)
);
